// ----- rtl/psme_pkg.sv -----
// Shared types, constants and arithmetic helpers for the packed symmetric matrix engine.
package psme_pkg;

    // Default largest matrix dimension.
    localparam int MAX_SIZE_DEF = 64;

    // Reset value of the active size register.
    localparam logic [6:0] ACTIVE_SIZE_RST = 7'd64;

    // Command codes.
    typedef enum logic [2:0] {
        CMD_WRITE = 3'd0,
        CMD_READ  = 3'd1,
        CMD_LOAD  = 3'd2,
        CMD_OUTER = 3'd3,
        CMD_QUAD  = 3'd4,
        CMD_TRACE = 3'd5
    } cmd_t;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_DECODE,
        S_EL,
        S_EL_WAIT,
        S_ROW,
        S_ROW_WAIT,
        S_RD,
        S_M1,
        S_M2,
        S_ACC,
        S_TR_RD,
        S_TR_ACC,
        S_DONE
    } state_t;

    typedef struct packed {
        logic               sat;
        logic signed [31:0] val;
    } sat32_t;

    typedef struct packed {
        logic               sat;
        logic signed [63:0] val;
    } sat64_t;

    localparam logic signed [63:0] S32_MAX = 64'sh000000007FFFFFFF;
    localparam logic signed [63:0] S32_MIN = 64'shFFFFFFFF80000000;

    // Q32.32 product back to Q16.16, rounding towards minus infinity.
    function automatic logic signed [63:0] rescale(input logic signed [63:0] v);
        return v >>> 16;
    endfunction

    // Clamp a wide value into the signed 32-bit range.
    function automatic sat32_t sat32(input logic signed [63:0] v);
        sat32_t r;
        if (v > S32_MAX)
        begin
            r.sat = 1'b1;
            r.val = 32'sh7FFFFFFF;
        end
        else if (v < S32_MIN)
        begin
            r.sat = 1'b1;
            r.val = 32'sh80000000;
        end
        else
        begin
            r.sat = 1'b0;
            r.val = v[31:0];
        end
        return r;
    endfunction

    // Signed 64-bit add that clamps on overflow.
    function automatic sat64_t sat_add64(input logic signed [63:0] a,
                                         input logic signed [63:0] b);
        sat64_t r;
        logic [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
        begin
            r.sat = 1'b1;
            r.val = a[63] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
        end
        else
        begin
            r.sat = 1'b0;
            r.val = s;
        end
        return r;
    endfunction

endpackage

// ----- rtl/psme_mul.sv -----
// Shared signed 32 by 32 multiplier with a registered product.
module psme_mul
(
    input  logic               clk,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [63:0] p
);

    logic signed [63:0] p_reg;

    // One product per cycle, registered before any further use.
    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

// ----- rtl/packed_symmetric_matrix_engine.sv -----
// Packed symmetric matrix engine: top level with sequencer, stores and stream ports.
//
// The engine holds a symmetric Q16.16 matrix in packed lower-triangular storage and a
// vector store, and answers one result transfer for every input transfer. After reset
// a clearing pass over every packed entry zeroes both stores; s_tready stays
// low until it ends. Outer accumulate and quadratic form walk the packed entries of
// the active size through the single shared multiplier and the one-port matrix store,
// and trace reads each diagonal entry in turn.
// One item is worked on at a time; a finished result waits in the output register
// while the next item is taken in.
module packed_symmetric_matrix_engine
#(
    parameter int MAX_SIZE = psme_pkg::MAX_SIZE_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: active size.
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    // Input stream, tdata from bit 0: command[2:0], row[8:3], col[14:9], value[46:15].
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,
    // Output stream, tdata from bit 0: result[63:0], status[65:64].
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata
);

    localparam int DEPTH = MAX_SIZE * (MAX_SIZE + 1) / 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(MAX_SIZE);
    localparam int NW    = $clog2(MAX_SIZE + 1);
    localparam int CW    = (NW > 7) ? NW : 7;
    localparam int TW    = 2 * IW + 2;

    psme_pkg::state_t state_reg, state_next;

    logic [6:0]         active_reg;
    logic [AW-1:0]      clr_reg, clr_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic signed [63:0] out_result_reg, out_result_next;
    logic [1:0]         out_status_reg, out_status_next;

    logic [2:0]         cmd_reg, cmd_next;
    logic [5:0]         row_reg, row_next;
    logic [5:0]         col_reg, col_next;
    logic signed [31:0] val_reg, val_next;
    logic [IW-1:0]      i_reg, i_next;
    logic [IW-1:0]      j_reg, j_next;
    logic [AW-1:0]      k_reg, k_next;
    logic signed [63:0] acc_reg, acc_next;
    logic               sat_reg, sat_next;
    logic [1:0]         stat_reg, stat_next;
    logic signed [31:0] vi_reg, vi_next;

    // Stores.
    logic signed [31:0] mat_mem [DEPTH];
    logic signed [31:0] vec_mem [MAX_SIZE];
    logic signed [31:0] mat_q_reg;
    logic signed [31:0] vec_q_reg;
    logic               mat_we, mat_re, vec_we, vec_re;
    logic [AW-1:0]      mat_addr;
    logic signed [31:0] mat_wd, vec_wd;
    logic [IW-1:0]      vec_wa, vec_ra;

    // Multiplier.
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod;

    // Decode helpers.
    logic [CW-1:0]      n_eff;
    logic               row_bad, col_bad, last_row, last_col, is_quad;
    logic [IW-1:0]      rr, cc;
    logic [TW-1:0]      tri_full;
    logic [AW-1:0]      el_addr;
    psme_pkg::sat32_t   t_sat, upd_sat;
    psme_pkg::sat64_t   add_r;
    logic signed [63:0] term;

    psme_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // Effective size and range checks.
    always_comb
    begin
        n_eff    = (CW'(active_reg) > CW'(MAX_SIZE)) ? CW'(MAX_SIZE) : CW'(active_reg);
        row_bad  = CW'(row_reg) >= n_eff;
        col_bad  = CW'(col_reg) >= n_eff;
        last_row = CW'(i_reg) == n_eff - CW'(1);
        last_col = j_reg == i_reg;
        is_quad  = cmd_reg == psme_pkg::CMD_QUAD;
        rr       = (row_reg >= col_reg) ? IW'(row_reg) : IW'(col_reg);
        cc       = (row_reg >= col_reg) ? IW'(col_reg) : IW'(row_reg);
        tri_full = TW'(rr) * (TW'(rr) + TW'(1));
        el_addr  = AW'(tri_full >> 1) + AW'(cc);
    end

    // Shared multiplier operand selection and step arithmetic.
    always_comb
    begin
        t_sat   = psme_pkg::sat32(psme_pkg::rescale(prod));
        upd_sat = psme_pkg::sat32(64'(mat_q_reg) + psme_pkg::rescale(prod));
        mul_a   = vi_reg;
        mul_b   = vec_q_reg;
        if (state_reg == psme_pkg::S_M1 && is_quad)
        begin
            mul_a = mat_q_reg;
            mul_b = vi_reg;
        end
        else if (state_reg == psme_pkg::S_M2)
        begin
            mul_a = t_sat.val;
            mul_b = vec_q_reg;
        end
        if (state_reg == psme_pkg::S_TR_ACC)
            term = 64'(mat_q_reg);
        else if (last_col)
            term = psme_pkg::rescale(prod);
        else
            term = psme_pkg::rescale(prod) <<< 1;
        add_r = psme_pkg::sat_add64(acc_reg, term);
    end

    // Sequencer: next state, store controls and datapath updates.
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        m_tvalid_next   = m_tvalid_reg;
        out_result_next = out_result_reg;
        out_status_next = out_status_reg;
        cmd_next        = cmd_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        val_next        = val_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        acc_next        = acc_reg;
        sat_next        = sat_reg;
        stat_next       = stat_reg;
        vi_next         = vi_reg;
        mat_we          = 1'b0;
        mat_re          = 1'b0;
        mat_addr        = k_reg;
        mat_wd          = val_reg;
        vec_we          = 1'b0;
        vec_re          = 1'b0;
        vec_wa          = IW'(row_reg);
        vec_wd          = val_reg;
        vec_ra          = j_reg;
        s_tready        = 1'b0;

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        unique case (state_reg)
            psme_pkg::S_CLEAR:
            begin
                mat_we   = 1'b1;
                mat_addr = clr_reg;
                mat_wd   = '0;
                vec_wa   = clr_reg[IW-1:0];
                vec_wd   = '0;
                vec_we   = clr_reg < AW'(MAX_SIZE);
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                    state_next = psme_pkg::S_IDLE;
            end
            psme_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd_next   = s_tdata[2:0];
                    row_next   = s_tdata[8:3];
                    col_next   = s_tdata[14:9];
                    val_next   = s_tdata[46:15];
                    state_next = psme_pkg::S_DECODE;
                end
            end
            psme_pkg::S_DECODE:
            begin
                acc_next   = '0;
                sat_next   = 1'b0;
                stat_next  = psme_pkg::ST_OK;
                i_next     = '0;
                j_next     = '0;
                k_next     = '0;
                state_next = psme_pkg::S_DONE;
                unique case (cmd_reg) inside
                    psme_pkg::CMD_WRITE, psme_pkg::CMD_READ:
                    begin
                        if (row_bad || col_bad)
                            stat_next = psme_pkg::ST_RANGE;
                        else
                        begin
                            k_next     = el_addr;
                            state_next = psme_pkg::S_EL;
                        end
                    end
                    psme_pkg::CMD_LOAD:
                    begin
                        if (row_bad)
                            stat_next = psme_pkg::ST_RANGE;
                        else
                            vec_we = 1'b1;
                    end
                    psme_pkg::CMD_OUTER, psme_pkg::CMD_QUAD:
                    begin
                        if (n_eff != '0)
                            state_next = psme_pkg::S_ROW;
                    end
                    psme_pkg::CMD_TRACE:
                    begin
                        if (n_eff != '0)
                            state_next = psme_pkg::S_TR_RD;
                    end
                    default:
                    begin
                    end
                endcase
            end
            psme_pkg::S_EL:
            begin
                if (cmd_reg == psme_pkg::CMD_WRITE)
                begin
                    mat_we     = 1'b1;
                    state_next = psme_pkg::S_DONE;
                end
                else
                begin
                    mat_re     = 1'b1;
                    state_next = psme_pkg::S_EL_WAIT;
                end
            end
            psme_pkg::S_EL_WAIT:
            begin
                acc_next   = 64'(mat_q_reg);
                state_next = psme_pkg::S_DONE;
            end
            psme_pkg::S_ROW:
            begin
                vec_re     = 1'b1;
                vec_ra     = i_reg;
                state_next = psme_pkg::S_ROW_WAIT;
            end
            psme_pkg::S_ROW_WAIT:
            begin
                vi_next    = vec_q_reg;
                state_next = psme_pkg::S_RD;
            end
            psme_pkg::S_RD:
            begin
                mat_re     = 1'b1;
                vec_re     = 1'b1;
                state_next = psme_pkg::S_M1;
            end
            psme_pkg::S_M1:
            begin
                state_next = psme_pkg::S_M2;
            end
            psme_pkg::S_M2, psme_pkg::S_ACC:
            begin
                if (state_reg == psme_pkg::S_M2 && is_quad)
                begin
                    sat_next   = sat_reg | t_sat.sat;
                    state_next = psme_pkg::S_ACC;
                end
                else
                begin
                    if (state_reg == psme_pkg::S_M2)
                    begin
                        mat_we   = 1'b1;
                        mat_wd   = upd_sat.val;
                        sat_next = sat_reg | upd_sat.sat;
                    end
                    else
                    begin
                        acc_next = add_r.val;
                        sat_next = sat_reg | add_r.sat;
                    end
                    // Step to the next packed entry.
                    if (last_col)
                    begin
                        if (last_row)
                            state_next = psme_pkg::S_DONE;
                        else
                        begin
                            i_next     = i_reg + IW'(1);
                            j_next     = '0;
                            k_next     = k_reg + AW'(1);
                            state_next = psme_pkg::S_ROW;
                        end
                    end
                    else
                    begin
                        j_next     = j_reg + IW'(1);
                        k_next     = k_reg + AW'(1);
                        state_next = psme_pkg::S_RD;
                    end
                end
            end
            psme_pkg::S_TR_RD:
            begin
                mat_re     = 1'b1;
                state_next = psme_pkg::S_TR_ACC;
            end
            psme_pkg::S_TR_ACC:
            begin
                acc_next = add_r.val;
                sat_next = sat_reg | add_r.sat;
                if (last_row)
                    state_next = psme_pkg::S_DONE;
                else
                begin
                    i_next     = i_reg + IW'(1);
                    k_next     = k_reg + AW'(i_reg) + AW'(2);
                    state_next = psme_pkg::S_TR_RD;
                end
            end
            psme_pkg::S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next   = 1'b1;
                    out_result_next = acc_reg;
                    out_status_next = sat_reg ? psme_pkg::ST_SAT : stat_reg;
                    state_next      = psme_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = psme_pkg::S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= psme_pkg::S_CLEAR;
        else
            state_reg <= state_next;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            active_reg   <= psme_pkg::ACTIVE_SIZE_RST;
        end
        else
        begin
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we)
                active_reg <= cfg_wdata;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        out_result_reg <= out_result_next;
        out_status_reg <= out_status_next;
        cmd_reg        <= cmd_next;
        row_reg        <= row_next;
        col_reg        <= col_next;
        val_reg        <= val_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        k_reg          <= k_next;
        acc_reg        <= acc_next;
        sat_reg        <= sat_next;
        stat_reg       <= stat_next;
        vi_reg         <= vi_next;
    end

    // Packed matrix store.
    always_ff @(posedge clk)
    begin
        if (mat_we)
            mat_mem[mat_addr] <= mat_wd;
        if (mat_re)
            mat_q_reg <= mat_mem[mat_addr];
    end

    // Vector store.
    always_ff @(posedge clk)
    begin
        if (vec_we)
            vec_mem[vec_wa] <= vec_wd;
        if (vec_re)
            vec_q_reg <= vec_mem[vec_ra];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, out_status_reg, out_result_reg};

    // An accepted transfer closes the input until its result is built.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in progress");

    // No input is taken during the clearing pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == psme_pkg::S_CLEAR) |-> !s_tready)
        else $error("input ready during clearing pass");

    // A range error always carries a zero result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[65:64] == psme_pkg::ST_RANGE) |-> (m_tdata[63:0] == 64'd0))
        else $error("range error with non-zero result");

    // The walk never leaves the packed store.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == psme_pkg::S_RD || state_reg == psme_pkg::S_TR_RD)
            |-> (k_reg <= AW'(DEPTH - 1)))
        else $error("packed address beyond store");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the packed symmetric matrix engine.
`timescale 1ns / 1ps

module testbench;

    localparam int MAXN = psme_pkg::MAX_SIZE_DEF;
    localparam int DEPTH = MAXN * (MAXN + 1) / 2;

    // Command codes that the engine leaves unused.
    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;

    typedef struct packed {
        logic [2:0]  command;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [31:0] value;
    } cmd_item_t;

    typedef struct packed {
        logic [63:0] result;
        logic [1:0]  status;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [6:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;

    packed_symmetric_matrix_engine dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Shadow copy of the engine state.
    logic signed [31:0] shadow_mat [DEPTH];
    logic signed [31:0] shadow_vec [MAXN];
    logic [6:0]         shadow_size;

    cmd_item_t pending_cmds [$];
    answer_t   expected_answers [$];
    int        error_count;
    bit        calm_phase;
    bit        hold_off_req;
    bit        in_accepted;

    function automatic int tri_index(int r, int c);
        int t;
        if (r < c)
        begin
            t = r;
            r = c;
            c = t;
        end
        return r * (r + 1) / 2 + c;
    endfunction

    function automatic logic signed [63:0] clamp32(logic signed [63:0] v, ref bit sat);
        if (v > 64'sh7FFFFFFF)
        begin
            sat = 1;
            return 64'sh7FFFFFFF;
        end
        if (v < -64'sh80000000)
        begin
            sat = 1;
            return -64'sh80000000;
        end
        return v;
    endfunction

    function automatic logic signed [63:0] acc64(logic signed [63:0] a,
                                                 logic signed [63:0] b, ref bit sat);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(64'sh7FFFFFFFFFFFFFFF))
        begin
            sat = 1;
            return 64'sh7FFFFFFFFFFFFFFF;
        end
        if (s < 65'(64'sh8000000000000000))
        begin
            sat = 1;
            return 64'sh8000000000000000;
        end
        return s[63:0];
    endfunction

    // Unpack the fields of one input transfer.
    function automatic cmd_item_t decode_input(logic [47:0] d);
        cmd_item_t it;
        it.command = d[2:0];
        it.row     = d[8:3];
        it.col     = d[14:9];
        it.value   = d[46:15];
        return it;
    endfunction

    // Apply one command to the shadow state and return the expected answer.
    function automatic answer_t predict_answer(cmd_item_t it);
        answer_t a;
        int n;
        bit sat;
        logic signed [63:0] acc, prod, t, upd;
        n = (shadow_size > MAXN) ? MAXN : int'(shadow_size);
        acc = 0;
        sat = 0;
        a.status = psme_pkg::ST_OK;
        case (it.command)
            psme_pkg::CMD_WRITE, psme_pkg::CMD_READ:
            begin
                if (it.row >= n || it.col >= n)
                    a.status = psme_pkg::ST_RANGE;
                else if (it.command == psme_pkg::CMD_WRITE)
                    shadow_mat[tri_index(it.row, it.col)] = it.value;
                else
                    acc = 64'(shadow_mat[tri_index(it.row, it.col)]);
            end
            psme_pkg::CMD_LOAD:
            begin
                if (it.row >= n)
                    a.status = psme_pkg::ST_RANGE;
                else
                    shadow_vec[it.row] = it.value;
            end
            psme_pkg::CMD_OUTER:
                for (int i = 0; i < n; i++)
                    for (int j = 0; j <= i; j++)
                    begin
                        prod = (64'(shadow_vec[i]) * 64'(shadow_vec[j])) >>> 16;
                        upd = clamp32(64'(shadow_mat[tri_index(i, j)]) + prod, sat);
                        shadow_mat[tri_index(i, j)] = upd[31:0];
                    end
            psme_pkg::CMD_QUAD:
                for (int i = 0; i < n; i++)
                    for (int j = 0; j <= i; j++)
                    begin
                        t = clamp32((64'(shadow_mat[tri_index(i, j)])
                                     * 64'(shadow_vec[i])) >>> 16, sat);
                        prod = (t * 64'(shadow_vec[j])) >>> 16;
                        if (i != j)
                            prod = prod * 2;
                        acc = acc64(acc, prod, sat);
                    end
            psme_pkg::CMD_TRACE:
                for (int i = 0; i < n; i++)
                    acc = acc64(acc, 64'(shadow_mat[tri_index(i, i)]), sat);
            default:
            begin
            end
        endcase
        if (sat)
            a.status = psme_pkg::ST_SAT;
        a.result = (a.status == psme_pkg::ST_RANGE) ? 64'd0 : acc;
        return a;
    endfunction

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Overall time limit.
    initial
    begin
        #200ms;
        $display("testbench: done, errors");
        $finish;
    end

    // Sender: an offered item is held until its transfer, with random gaps between outside the calm phase.
    int send_gap;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && !in_accepted)
            begin
            end
            else
            begin
                in_accepted = 1'b0;
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_cmds.size() > 0 && !calm_phase
                         && $urandom_range(0, 9) == 0)
                begin
                    send_gap <= $urandom_range(1, 15);
                    s_tvalid <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {1'b0, pending_cmds[0].value, pending_cmds[0].col,
                                 pending_cmds[0].row, pending_cmds[0].command};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Prediction on every accepted input transfer.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            expected_answers.push_back(predict_answer(decode_input(s_tdata)));
            void'(pending_cmds.pop_front());
            in_accepted = 1'b1;
        end
    end

    // Receiver back-pressure, including one long hold-off.
    int stall_left;
    always @(negedge clk)
    begin
        if (hold_off_req)
        begin
            stall_left   <= 400;
            hold_off_req <= 1'b0;
            m_tready     <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (!calm_phase && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(1, 15);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Result checking.
    always @(posedge clk)
    begin
        answer_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.result = m_tdata[63:0];
            got.status = m_tdata[65:64];
            if (expected_answers.size() == 0)
            begin
                $display("%0t: unexpected result %h status %0d", $time, got.result,
                         got.status);
                error_count++;
            end
            else
            begin
                want = expected_answers.pop_front();
                if (got.result !== want.result)
                begin
                    $display("%0t: result expected %h actual %h", $time, want.result,
                             got.result);
                    error_count++;
                end
                if (got.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             got.status);
                    error_count++;
                end
            end
        end
    end

    task automatic queue_cmd(logic [2:0] c, int r, int k, logic [31:0] v);
        cmd_item_t it;
        it.command = c;
        it.row = r[5:0];
        it.col = k[5:0];
        it.value = v;
        pending_cmds.push_back(it);
    endtask

    // Let the queue drain, all answers arrive, then write the size register.
    task automatic set_size(logic [6:0] sz);
        while (pending_cmds.size() > 0 || expected_answers.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        @(negedge clk);
        cfg_we      <= 1'b1;
        cfg_wdata   <= sz;
        shadow_size = sz;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom;
        endcase
    endfunction

    // Stimulus: directed commands, then random phases at several sizes.
    initial
    begin
        int sizes [5] = '{4, 1, 0, 100, 7};
        int sz;
        foreach (shadow_mat[i]) shadow_mat[i] = 0;
        foreach (shadow_vec[i]) shadow_vec[i] = 0;
        shadow_size  = psme_pkg::ACTIVE_SIZE_RST;
        error_count  = 0;
        calm_phase   = 0;
        hold_off_req = 0;
        in_accepted  = 0;
        send_gap     = 0;
        stall_left   = 0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: full-size trace, extremes, ranges, unused codes, saturation.
        queue_cmd(psme_pkg::CMD_TRACE, 0, 0, 0);
        queue_cmd(psme_pkg::CMD_WRITE, 63, 63, 32'h7FFFFFFF);
        queue_cmd(psme_pkg::CMD_READ, 63, 63, 0);
        queue_cmd(psme_pkg::CMD_WRITE, 0, 0, 32'h80000000);
        queue_cmd(psme_pkg::CMD_WRITE, 63, 0, 32'hFFFFFFFF);
        queue_cmd(psme_pkg::CMD_READ, 0, 63, 0);
        queue_cmd(psme_pkg::CMD_TRACE, 0, 0, 0);
        queue_cmd(CMD_SPARE_A, 63, 63, 32'hFFFFFFFF);
        queue_cmd(CMD_SPARE_B, 0, 0, 0);
        set_size(7'd3);
        queue_cmd(psme_pkg::CMD_WRITE, 3, 0, 1);
        queue_cmd(psme_pkg::CMD_READ, 0, 3, 0);
        queue_cmd(psme_pkg::CMD_LOAD, 3, 0, 5);
        queue_cmd(psme_pkg::CMD_LOAD, 0, 0, 32'h7FFFFFFF);
        queue_cmd(psme_pkg::CMD_LOAD, 1, 0, 32'h80000000);
        queue_cmd(psme_pkg::CMD_LOAD, 2, 0, 32'h00010000);
        queue_cmd(psme_pkg::CMD_OUTER, 0, 0, 0);
        queue_cmd(psme_pkg::CMD_QUAD, 0, 0, 0);
        queue_cmd(psme_pkg::CMD_TRACE, 0, 0, 0);
        queue_cmd(psme_pkg::CMD_READ, 1, 0, 0);
        queue_cmd(psme_pkg::CMD_WRITE, 2, 1, 32'h00020000);
        queue_cmd(psme_pkg::CMD_QUAD, 0, 0, 0);

        // Fill the engine while the receiver holds off.
        hold_off_req = 1;
        for (int i = 0; i < 10; i++)
            queue_cmd(psme_pkg::CMD_READ, i % 4, 0, 0);

        // Random phases.
        for (int p = 0; p < 5; p++)
        begin
            set_size(7'(sizes[p]));
            sz = (sizes[p] > MAXN) ? MAXN : sizes[p];
            if (p == 4)
                calm_phase = 1;
            for (int i = 0; i < 55; i++)
            begin
                int lim;
                lim = (sz == 0) ? 1 : sz + 1;
                case ($urandom_range(0, 9))
                    0, 1, 2: queue_cmd(psme_pkg::CMD_WRITE, $urandom_range(0, lim) % 64,
                                       $urandom_range(0, lim) % 64, rand_value());
                    3, 4: queue_cmd(psme_pkg::CMD_READ, $urandom_range(0, lim) % 64,
                                    $urandom_range(0, lim) % 64, 0);
                    5, 6: queue_cmd(psme_pkg::CMD_LOAD, $urandom_range(0, lim) % 64,
                                    $urandom, rand_value());
                    7: queue_cmd(($urandom_range(0, 1) == 0 || sz > 8) ? psme_pkg::CMD_TRACE
                                 : psme_pkg::CMD_OUTER, 0, 0, 0);
                    8: queue_cmd((sz > 8) ? psme_pkg::CMD_TRACE : psme_pkg::CMD_QUAD,
                                 $urandom, $urandom, 0);
                    default: queue_cmd(3'($urandom_range(0, 7)), $urandom, $urandom,
                                       $urandom);
                endcase
            end
        end

        while (pending_cmds.size() > 0 || expected_answers.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// ----- packed_symmetric_matrix_engine.f -----
rtl/psme_pkg.sv
rtl/psme_mul.sv
rtl/packed_symmetric_matrix_engine.sv
tb/testbench.sv
